@@ rtl/dlc_pkg.sv @@
`timescale 1ns / 1ps
package dlc_pkg;

    localparam int CAPACITY = 256;
    localparam int ITEM_W   = 8;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int SLOT_W   = $clog2(CAPACITY + 1);

    localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(CAPACITY);

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_BEGIN   = 3'd4,
        OP_END     = 3'd5,
        OP_NEXT    = 3'd6,
        OP_PRIOR   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_FREE,
        S_RD_LINK,
        S_LATCH,
        S_WR1,
        S_WR2,
        S_RD_DATA,
        S_CAPTURE
    } t_state;

endpackage

@@ rtl/dlc_if.sv @@
`timescale 1ns / 1ps
interface dlc_in_if;
    import dlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [ITEM_W-1:0] value;
    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface dlc_out_if;
    import dlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] cursor_value;
    logic              moved_ok;
    logic [1:0]        status;
    logic              is_empty;
    logic [SLOT_W-1:0] item_count;
    modport source (output valid, cursor_value, moved_ok, status, is_empty, item_count,
                    input ready);
    modport sink   (input valid, cursor_value, moved_ok, status, is_empty, item_count,
                    output ready);
endinterface

@@ rtl/dlc_ram.sv @@
`timescale 1ns / 1ps
module dlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/doubly_linked_cursor_list_core.sv @@
`timescale 1ns / 1ps
// Cursor list of byte items kept in a node store with forward and back links.
// Channels: i_cmd carries one operation word (op, value); o_rsp returns one
// result word per operation (cursor value, success, status, empty, count).
// A word moves when valid and ready are both high at a rising edge.
// From acceptance an operation passes the read free, latch, write 1, write 2,
// data read and capture states to the result register, with a read link state
// added when an insert takes its slot from the free chain. The three node
// memories are single ported with a registered read, so each op runs as read
// links, latch, two write steps and a data read in turn. A new op waits for
// the last to leave capture, as i_cmd.ready is high only in the idle state.
// Reset (synchronous, active low) empties the list: head, tail, cursor and
// free chain go to none, the fresh slot mark and the count to zero. Node
// memories are not cleared; read data is used only from slots already written.
// When the receiver stalls the result stays in the output register; the
// next operation may be accepted and worked, and it waits in the capture
// step until the output register frees.
module doubly_linked_cursor_list_core
    import dlc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlc_in_if.sink    i_cmd,
    dlc_out_if.source o_rsp
);

    t_state r_state, n_state;

    // latched operation word
    t_op               r_op;
    logic [ITEM_W-1:0] r_val;

    // list registers
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_free, n_free;
    logic [SLOT_W-1:0] r_fresh, n_fresh;
    logic [SLOT_W-1:0] r_count, n_count;

    // link values read for this op
    logic [SLOT_W-1:0] r_nxt, r_prv, r_fnext;
    logic              r_ok, n_ok;
    t_status           r_stat, n_stat;

    // result register
    logic              r_ov;
    logic [ITEM_W-1:0] r_o_val;
    logic              r_o_ok;
    t_status           r_o_stat;
    logic [SLOT_W-1:0] r_o_cnt;

    // memory ports
    logic [ADDR_W-1:0] d_addr, f_addr, b_addr;
    logic              d_we, f_we, b_we;
    logic [ITEM_W-1:0] d_wdata, d_rdata;
    logic [SLOT_W-1:0] f_wdata, f_rdata, b_wdata, b_rdata;

    dlc_ram #(.WIDTH(ITEM_W), .DEPTH(CAPACITY)) u_data (
        .i_clk(i_clk), .i_addr(d_addr), .i_we(d_we), .i_wdata(d_wdata), .o_rdata(d_rdata)
    );
    dlc_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_fwd (
        .i_clk(i_clk), .i_addr(f_addr), .i_we(f_we), .i_wdata(f_wdata), .o_rdata(f_rdata)
    );
    dlc_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_back (
        .i_clk(i_clk), .i_addr(b_addr), .i_we(b_we), .i_wdata(b_wdata), .o_rdata(b_rdata)
    );

    // derived conditions on the state before the op
    logic              list_empty, is_full, from_free, nxt_ok, prv_ok;
    logic [SLOT_W-1:0] new_slot, rem_head, dec_count;

    assign list_empty = (r_count == '0) || (r_cur >= NONE_SLOT);
    assign from_free  = (r_free < NONE_SLOT);
    assign is_full    = (r_count >= NONE_SLOT) || (!from_free && r_fresh >= NONE_SLOT);
    assign new_slot   = from_free ? r_free : r_fresh;
    assign nxt_ok     = (r_nxt < NONE_SLOT);
    assign prv_ok     = (r_prv < NONE_SLOT);
    assign rem_head   = prv_ok ? r_head : r_nxt;
    assign dec_count  = r_count - SLOT_W'(1);

    assign i_cmd.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NONE_SLOT;
            r_tail  <= NONE_SLOT;
            r_cur   <= NONE_SLOT;
            r_free  <= NONE_SLOT;
            r_fresh <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_count <= n_count;
            if (r_state == S_CAPTURE && (!r_ov || o_rsp.ready)) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_op  <= t_op'(i_cmd.op);
            r_val <= i_cmd.value;
        end
        if (r_state == S_RD_LINK) begin
            r_fnext <= f_rdata;
        end
        if (r_state == S_LATCH) begin
            r_nxt <= f_rdata;
            r_prv <= b_rdata;
        end
        r_ok   <= n_ok;
        r_stat <= n_stat;
        if (r_state == S_CAPTURE && (!r_ov || o_rsp.ready)) begin
            r_o_val  <= (r_count == '0) ? '0 : d_rdata;
            r_o_ok   <= r_ok;
            r_o_stat <= r_stat;
            r_o_cnt  <= r_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cur   = r_cur;
        n_free  = r_free;
        n_fresh = r_fresh;
        n_count = r_count;
        n_ok    = r_ok;
        n_stat  = r_stat;
        d_addr  = r_cur[ADDR_W-1:0];
        f_addr  = r_cur[ADDR_W-1:0];
        b_addr  = r_cur[ADDR_W-1:0];
        d_we    = 1'b0;
        f_we    = 1'b0;
        b_we    = 1'b0;
        d_wdata = r_val;
        f_wdata = NONE_SLOT;
        b_wdata = NONE_SLOT;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_RD_FREE;
                end
            end
            S_RD_FREE: begin
                // fetch the free chain successor for an insert from the free chain, else the cursor's forward link
                f_addr  = r_free[ADDR_W-1:0];
                n_state = (r_op == OP_INSERT && from_free) ? S_RD_LINK : S_LATCH;
                if (!(r_op == OP_INSERT && from_free)) begin
                    f_addr = r_cur[ADDR_W-1:0];
                end
            end
            S_RD_LINK: begin
                // links of the cursor node
                n_state = S_LATCH;
            end
            S_LATCH: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                n_state = S_WR2;
                unique case (r_op)
                    OP_INSERT: begin
                        if (!is_full) begin
                            d_addr  = new_slot[ADDR_W-1:0];
                            d_we    = 1'b1;
                            f_addr  = new_slot[ADDR_W-1:0];
                            f_we    = 1'b1;
                            f_wdata = list_empty ? NONE_SLOT : r_nxt;
                            b_addr  = new_slot[ADDR_W-1:0];
                            b_we    = 1'b1;
                            b_wdata = list_empty ? NONE_SLOT : r_cur;
                        end
                    end
                    OP_REMOVE: begin
                        if (!list_empty) begin
                            f_addr  = r_prv[ADDR_W-1:0];
                            f_we    = prv_ok;
                            f_wdata = r_nxt;
                            b_addr  = r_nxt[ADDR_W-1:0];
                            b_we    = nxt_ok;
                            b_wdata = r_prv;
                        end
                    end
                    OP_REPLACE: begin
                        d_we = !list_empty;
                    end
                    default: begin
                    end
                endcase
            end
            S_WR2: begin
                n_state = S_RD_DATA;
                n_ok    = 1'b0;
                n_stat  = ST_OK;
                unique case (r_op)
                    OP_CLEAR: begin
                        n_head  = NONE_SLOT;
                        n_tail  = NONE_SLOT;
                        n_cur   = NONE_SLOT;
                        n_free  = NONE_SLOT;
                        n_fresh = '0;
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    OP_INSERT: begin
                        if (is_full) begin
                            n_stat = ST_FULL;
                        end else begin
                            if (list_empty) begin
                                n_head = new_slot;
                                n_tail = new_slot;
                            end else begin
                                f_we    = 1'b1;
                                f_wdata = new_slot;
                                b_addr  = r_nxt[ADDR_W-1:0];
                                b_we    = nxt_ok;
                                b_wdata = new_slot;
                                if (!nxt_ok) begin
                                    n_tail = new_slot;
                                end
                            end
                            if (from_free) begin
                                n_free = r_fnext;
                            end else begin
                                n_fresh = r_fresh + SLOT_W'(1);
                            end
                            n_cur   = new_slot;
                            n_count = r_count + SLOT_W'(1);
                            n_ok    = 1'b1;
                        end
                    end
                    default: begin
                        if (list_empty) begin
                            n_stat = ST_EMPTY;
                        end else begin
                            priority case (r_op)
                                OP_REMOVE: begin
                                    // push the node onto the free chain
                                    f_we    = 1'b1;
                                    f_wdata = r_free;
                                    n_free  = r_cur;
                                    n_count = dec_count;
                                    n_ok    = 1'b1;
                                    if (dec_count == '0) begin
                                        n_head = NONE_SLOT;
                                        n_tail = NONE_SLOT;
                                        n_cur  = NONE_SLOT;
                                    end else begin
                                        n_head = rem_head;
                                        n_tail = nxt_ok ? r_tail : r_prv;
                                        n_cur  = nxt_ok ? r_nxt : rem_head;
                                    end
                                end
                                OP_REPLACE: n_ok = 1'b1;
                                OP_BEGIN: begin
                                    n_cur = r_head;
                                    n_ok  = 1'b1;
                                end
                                OP_END: begin
                                    n_cur = r_tail;
                                    n_ok  = 1'b1;
                                end
                                OP_NEXT: begin
                                    if (nxt_ok) begin
                                        n_cur = r_nxt;
                                        n_ok  = 1'b1;
                                    end
                                end
                                default: begin
                                    if (r_cur != r_head && prv_ok) begin
                                        n_cur = r_prv;
                                        n_ok  = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_RD_DATA: begin
                n_state = S_CAPTURE;
            end
            S_CAPTURE: begin
                // hold the data read port on the cursor while stalled
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.cursor_value = r_o_val;
    assign o_rsp.moved_ok     = r_o_ok;
    assign o_rsp.status       = r_o_stat;
    assign o_rsp.is_empty     = (r_o_cnt == '0);
    assign o_rsp.item_count   = r_o_cnt;

    // count and cursor agree: an empty list has no cursor, a filled one has
    a_cur_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_cur == NONE_SLOT))
        else $error("cursor and item count disagree");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NONE_SLOT)
        else $error("item count above capacity");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NONE_SLOT && r_tail == NONE_SLOT))
        else $error("empty list keeps a head or tail");

    a_fail_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_stat != ST_OK) |-> !r_o_ok)
        else $error("failed op reports success");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_cmd.ready)
        else $error("command taken while busy");

endmodule
